/* src/wrvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrvt_pkg
// Shared widths, operation codes and beat types of the weighted running
// variance table.
// ----------------------------------------------------------------------------
package wrvt_pkg;

    // default table depth
    localparam int NUM_CELLS_DEF = 1024;

    // field widths
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int MEAN_W = 24;
    localparam int WSUM_W = 32;
    localparam int DEV_W  = 48;
    localparam int VAR_W  = 24;

    // serial multiplier: a is the multiplicand, b is consumed one bit a cycle
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // serial divider: one quotient bit a cycle
    localparam int DIVD_W = 56;
    localparam int DIVS_W = WSUM_W;
    localparam int DIVQ_W = 25;
    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] DIV_STEPS_RD  = 6'd56;
    localparam logic [STEP_W-1:0] DIV_STEPS_ACC = 6'd40;

    // operation codes
    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // fixed point ones
    localparam logic [VAL_W-1:0]  ONE_Q15 = 16'h8000;
    localparam logic [MEAN_W-1:0] ONE_Q23 = 24'h80_0000;

    typedef struct packed {
        logic [1:0]       operation;
        logic [IDX_W-1:0] cell_index;
        logic [VAL_W-1:0] sample_value;
        logic [VAL_W-1:0] sample_weight;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_out;
        logic [WSUM_W-1:0] weight_sum_out;
        logic [DEV_W-1:0]  deviation_sum_out;
        logic [VAR_W-1:0]  variance_out;
        logic              zero_weight;
    } out_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [WSUM_W-1:0] wsum;
        logic [DEV_W-1:0]  dev;
    } cell_t;

endpackage

/* src/wrvt_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrvt_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module wrvt_mul import wrvt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [PROD_W-1:0]  prod
);

    localparam int CNT_W = $clog2(MUL_B_W + 1);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W-1:0] hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_A_W:0]   sum_next;

    // partial product add for the current multiplier bit
    assign sum_next = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_B_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // product shift register
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum_next[MUL_A_W:1];
            lo_reg <= {sum_next[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

/* src/wrvt_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrvt_div
// Restoring divider, one dividend bit shifted in and one quotient bit out
// per cycle; quotient bits above its width set a sticky overflow flag.
// ----------------------------------------------------------------------------
module wrvt_div import wrvt_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    input  logic [STEP_W-1:0] steps,
    output logic              done,
    output logic [DIVQ_W-1:0] quotient,
    output logic              overflow
);

    logic [DIVD_W-1:0] dsh_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVQ_W-1:0] q_reg;
    logic              ovf_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;
    logic [DIVS_W-1:0] rem_next;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial    = {rem_reg, dsh_reg[DIVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == STEP_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge aclk) begin
        if (start) begin
            dsh_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            dsh_reg <= {dsh_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[DIVQ_W-2:0], fits};
            ovf_reg <= ovf_reg | q_reg[DIVQ_W-1];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
    assign overflow = ovf_reg;

endmodule

/* src/weighted_running_variance_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_running_variance_table_unit
// Table of per-cell weighted mean, weight sum and squared-deviation sum,
// updated with West's incremental method.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation beat (accumulate, read variance, clear) on one
//   cell; every accepted beat yields exactly one m_* result beat with the
//   cell contents after the operation. Both sides are valid/ready.
//   After reset the table is swept to zero, one cell per cycle, with s_ready
//   low. Items are then handled one at a time. Per item: the cell index is
//   reduced modulo NUM_CELLS (one index bit a cycle), then the cell is read.
//   Clear and the spare code then finish. Accumulate runs the serial multiplier
//   twice and the serial divider for 40 quotient bits; Read runs the divider
//   for 56 quotient bits. Both skip the arithmetic if the weight sum is zero.
//   The result sits in an output register; s_ready comes back once it is
//   loaded, so the next item is taken while m_ready is low. A stalled
//   receiver holds the next result in its final step until the register
//   frees up.
// ----------------------------------------------------------------------------
module weighted_running_variance_table_unit import wrvt_pkg::*; #(
    parameter int NUM_CELLS = NUM_CELLS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int MCNT_W = $clog2(IDX_W + 1);
    localparam logic [ADDR_W:0]   CELLS_C = (ADDR_W + 1)'(NUM_CELLS);
    localparam logic [ADDR_W-1:0] LAST_C  = ADDR_W'(NUM_CELLS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_RD,
        ST_LOAD,
        ST_MUL1,
        ST_DIV_ACC,
        ST_MAG2,
        ST_MUL2,
        ST_DIV_RD,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [1:0]        op_reg;
    logic [VAL_W-1:0]  x_reg;
    logic [VAL_W-1:0]  w_reg;
    logic [IDX_W-1:0]  idx_sh_reg;
    logic [MCNT_W-1:0] mcnt_reg;
    logic [ADDR_W-1:0] cell_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [WSUM_W-1:0] wsum_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [VAR_W-1:0]  var_reg;
    logic              neg_reg;
    logic [MUL_A_W-1:0] p1_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    // table memory
    cell_t             mem_array [NUM_CELLS];
    cell_t             rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cell_t             wr_data;

    // shared arithmetic units
    logic               mul_start;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic [STEP_W-1:0]  div_steps;
    logic               div_done;
    logic [DIVQ_W-1:0]  div_q;
    logic               div_ovf;

    // datapath helpers
    logic [ADDR_W:0]    mod_trial;
    logic [ADDR_W:0]    mod_diff;
    logic [ADDR_W-1:0]  cell_next;
    logic [MEAN_W-1:0]  x23;
    logic [WSUM_W:0]    wsum_sum;
    logic [WSUM_W-1:0]  wsum_next;
    logic               neg_next;
    logic [MEAN_W-1:0]  mag1;
    logic [MEAN_W-1:0]  delta;
    logic [MEAN_W-1:0]  mean_next;
    logic [MEAN_W-1:0]  mag2;
    logic [WSUM_W-1:0]  inc;
    logic [DEV_W:0]     dev_sum;
    logic [DEV_W-1:0]   dev_next;
    logic               out_free;

    wrvt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    wrvt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    // index reduction step, one index bit per cycle
    always_comb begin
        mod_trial = {cell_reg, idx_sh_reg[IDX_W-1]};
        mod_diff  = mod_trial - CELLS_C;
        cell_next = (mod_trial >= CELLS_C) ? mod_diff[ADDR_W-1:0] : mod_trial[ADDR_W-1:0];
    end

    // weight sum update and first deviation from the stored cell
    always_comb begin
        x23       = {x_reg, 8'h00};
        wsum_sum  = {1'b0, rd_data_reg.wsum} + (WSUM_W + 1)'(w_reg);
        wsum_next = wsum_sum[WSUM_W] ? '1 : wsum_sum[WSUM_W-1:0];
        neg_next  = (x23 < rd_data_reg.mean);
        mag1      = neg_next ? (rd_data_reg.mean - x23) : (x23 - rd_data_reg.mean);
    end

    // mean step, second deviation and deviation sum update
    always_comb begin
        delta     = div_q[MEAN_W-1:0];
        mean_next = neg_reg ? (mean_reg - delta) : (mean_reg + delta);
        mag2      = neg_reg ? (mean_reg - x23) : (x23 - mean_reg);
        inc       = mul_prod[62:31];
        dev_sum   = {1'b0, dev_reg} + (DEV_W + 1)'(inc);
        dev_next  = dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];
    end

    // arithmetic unit operand selection
    always_comb begin
        mul_start = ((state_reg == ST_LOAD) && (op_reg == OP_ACCUM) && (wsum_next != '0))
                    || (state_reg == ST_MAG2);
        mul_a     = (state_reg == ST_LOAD) ? MUL_A_W'(mag1) : p1_reg;
        mul_b     = (state_reg == ST_LOAD) ? MUL_B_W'(w_reg) : mag2;

        div_start = ((state_reg == ST_LOAD) && (op_reg == OP_READ)
                     && (rd_data_reg.wsum != '0))
                    || ((state_reg == ST_MUL1) && mul_done);
        if (state_reg == ST_LOAD) begin
            div_dividend = {rd_data_reg.dev, 8'h00};
            div_divisor  = rd_data_reg.wsum;
            div_steps    = DIV_STEPS_RD;
        end else begin
            div_dividend = {mul_prod[MUL_A_W-1:0], 16'h0000};
            div_divisor  = wsum_reg;
            div_steps    = DIV_STEPS_ACC;
        end
    end

    // memory write port
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        wr_en    = (state_reg == ST_CLEAR) || ((state_reg == ST_DONE) && out_free);
        wr_addr  = (state_reg == ST_CLEAR) ? clr_addr_reg : cell_reg;
        if (state_reg == ST_CLEAR) begin
            wr_data = '0;
        end else begin
            wr_data = '{mean: mean_reg, wsum: wsum_reg, dev: dev_reg};
        end
    end

    // table storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_array[cell_reg];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // result taken, unless a new one is loaded on the same edge
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == LAST_C) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_data.operation;
                        x_reg      <= (s_data.sample_value > ONE_Q15) ? ONE_Q15
                                                                      : s_data.sample_value;
                        w_reg      <= (s_data.sample_weight > ONE_Q15) ? ONE_Q15
                                                                       : s_data.sample_weight;
                        idx_sh_reg <= s_data.cell_index;
                        mcnt_reg   <= MCNT_W'(IDX_W);
                        cell_reg   <= '0;
                        var_reg    <= '0;
                        state_reg  <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    cell_reg   <= cell_next;
                    idx_sh_reg <= {idx_sh_reg[IDX_W-2:0], 1'b0};
                    mcnt_reg   <= mcnt_reg - 1'b1;
                    if (mcnt_reg == MCNT_W'(1)) begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    neg_reg <= neg_next;
                    case (op_reg)
                        OP_ACCUM: begin
                            mean_reg  <= rd_data_reg.mean;
                            wsum_reg  <= wsum_next;
                            dev_reg   <= rd_data_reg.dev;
                            state_reg <= (wsum_next == '0) ? ST_DONE : ST_MUL1;
                        end
                        OP_READ: begin
                            mean_reg  <= rd_data_reg.mean;
                            wsum_reg  <= rd_data_reg.wsum;
                            dev_reg   <= rd_data_reg.dev;
                            state_reg <= (rd_data_reg.wsum == '0) ? ST_DONE : ST_DIV_RD;
                        end
                        OP_CLEAR: begin
                            mean_reg  <= '0;
                            wsum_reg  <= '0;
                            dev_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        default: begin
                            mean_reg  <= rd_data_reg.mean;
                            wsum_reg  <= rd_data_reg.wsum;
                            dev_reg   <= rd_data_reg.dev;
                            state_reg <= ST_DONE;
                        end
                    endcase
                end
                ST_MUL1: begin
                    if (mul_done) begin
                        p1_reg    <= mul_prod[MUL_A_W-1:0];
                        state_reg <= ST_DIV_ACC;
                    end
                end
                ST_DIV_ACC: begin
                    if (div_done) begin
                        mean_reg  <= mean_next;
                        state_reg <= ST_MAG2;
                    end
                end
                ST_MAG2: begin
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    if (mul_done) begin
                        dev_reg   <= dev_next;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DIV_RD: begin
                    if (div_done) begin
                        var_reg <= (div_ovf || (div_q > DIVQ_W'(ONE_Q23)))
                                   ? ONE_Q23 : div_q[VAR_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg                  <= 1'b1;
                        m_data_reg.mean_out          <= mean_reg;
                        m_data_reg.weight_sum_out    <= wsum_reg;
                        m_data_reg.deviation_sum_out <= dev_reg;
                        m_data_reg.variance_out      <= var_reg;
                        m_data_reg.zero_weight       <= (wsum_reg == '0);
                        state_reg                    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
